// File: hdl/nrte_pkg.sv
package nrte_pkg;

  localparam int FIELD_CAPACITY = 16;
  localparam int LEN_W          = $clog2(FIELD_CAPACITY + 1);
  localparam int NIB_DEPTH      = 4;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Fields shorter than this many characters carry no usable time.
  localparam logic [LEN_W-1:0] MIN_TIME_LEN = LEN_W'(8);

  typedef logic [3:0] nibble_t;

  typedef struct packed {
    logic    hour_tens;
    nibble_t hour_units;
    nibble_t minute_tens;
    nibble_t minute_units;
  } digits_t;

  localparam digits_t SHOWN_RESET   = '{1'b1, 4'd1, 4'd2, 4'd3};
  // Pending digits are always rewritten before they are compared.
  localparam digits_t PENDING_RESET = '{1'b1, 4'd4, 4'd5, 4'd6};

  // Expected character of "$GPRMC," at each header position.
  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      3'd6:    c = CHAR_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/nrte_local_hour.sv
// UTC hour digits to local 12-hour hour digits.
module nrte_local_hour (
  input  nrte_pkg::nibble_t utc_tens,
  input  nrte_pkg::nibble_t utc_units,
  input  logic [3:0]        zone_offset,
  output logic              local_tens,
  output nrte_pkg::nibble_t local_units
);

  logic [7:0] hour_raw;
  logic [7:0] hour_12;
  logic [7:0] hour_adj;
  logic [8:0] diff;
  logic [8:0] diff_m10;
  logic       above_nine;

  always_comb begin
    hour_raw = {1'b0, utc_tens, 3'b000} + {3'b000, utc_tens, 1'b0} + {4'b0000, utc_units};
    hour_12  = (hour_raw > 8'd12) ? hour_raw - 8'd12 : hour_raw;
    hour_adj = (hour_12 <= {4'b0000, zone_offset}) ? hour_12 + 8'd12 : hour_12;
    diff     = {1'b0, hour_adj} - {5'b00000, zone_offset};
    diff_m10 = diff - 9'd10;
    // A negative difference wraps high, so it counts as above nine.
    above_nine  = diff[8] | (diff[7:0] > 8'd9);
    local_tens  = above_nine;
    local_units = above_nine ? diff_m10[3:0] : diff[3:0];
  end

endmodule

// File: hdl/nmea_rmc_time_extractor.sv
// NMEA RMC time extractor.
//
// Input channel (in_valid/in_ready/in_rx_byte): one received NMEA character
// per transaction. The block hunts for "$GPRMC,", collects the time field
// up to the next comma and turns HHMM into local 12-hour time using the
// zone offset (cfg_wr_en/cfg_zone_offset_hours, reset value 4). A time
// field of seven characters or fewer yields all-zero digits.
// Output channel (out_valid/out_ready/out_*): one transaction carrying four
// digits, sent only when they differ from the digits last sent.
// Result: registered, valid in the cycle after the byte following the
// closing comma is accepted. Throughput: one byte per cycle while in_ready
// is high; every byte is handled in the cycle it is accepted against the
// parser state registers. Stall: a result waits in the output register.
// Bytes keep flowing while it waits; only the byte that would launch a new
// result is held off (in_ready low) until the waiting result is taken.
// Reset (rst_n low, synchronous): parser back to hunting for '$', offset 4,
// output register empty, last-shown digits 1,1,2,3.
module nmea_rmc_time_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_hour_tens,
  output logic [3:0] out_hour_units,
  output logic [3:0] out_minute_tens,
  output logic [3:0] out_minute_units,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_zone_offset_hours
);

  typedef enum logic [3:0] {
    PH_DOLLAR = 4'd0,
    PH_G      = 4'd1,
    PH_P      = 4'd2,
    PH_R      = 4'd3,
    PH_M      = 4'd4,
    PH_C      = 4'd5,
    PH_COMMA  = 4'd6,
    PH_TIME   = 4'd7,
    PH_SKIP   = 4'd8
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [nrte_pkg::LEN_W-1:0]   len_r, len_nxt;
  nrte_pkg::nibble_t            nib_r [nrte_pkg::NIB_DEPTH];
  nrte_pkg::nibble_t            nib_nxt [nrte_pkg::NIB_DEPTH];
  nrte_pkg::digits_t            pend_r, pend_nxt;
  nrte_pkg::digits_t            shown_r, shown_nxt;
  nrte_pkg::digits_t            out_r;
  logic                         out_valid_r;
  logic [3:0]                   zone_r;

  logic                         accept;
  logic                         changed;
  logic                         emit;
  logic                         loc_tens;
  nrte_pkg::nibble_t            loc_units;
  nrte_pkg::digits_t            formed;

  // Local hour from the first two captured characters.
  nrte_local_hour u_hour (
    .utc_tens    (nib_r[0]),
    .utc_units   (nib_r[1]),
    .zone_offset (zone_r),
    .local_tens  (loc_tens),
    .local_units (loc_units)
  );

  assign changed = (pend_r != shown_r);

  // Hold off only the byte that would launch a result while the output
  // register is still occupied and stalled.
  assign in_ready = !((phase_r == PH_SKIP) && changed && out_valid_r && !out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (len_r >= nrte_pkg::MIN_TIME_LEN) begin
      formed = '{loc_tens, loc_units, nib_r[2], nib_r[3]};
    end else begin
      formed = '0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    nib_nxt   = nib_r;
    pend_nxt  = pend_r;
    shown_nxt = shown_r;
    emit      = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_DOLLAR, PH_G, PH_P, PH_R, PH_M, PH_C, PH_COMMA: begin
          if (phase_r == PH_COMMA) begin
            len_nxt = '0;
          end
          if (in_rx_byte == nrte_pkg::header_char(phase_r[2:0])) begin
            phase_nxt = phase_t'(phase_r + 4'd1);
          end else begin
            phase_nxt = PH_DOLLAR;
          end
        end
        PH_TIME: begin
          if (in_rx_byte == nrte_pkg::CHAR_COMMA) begin
            pend_nxt  = formed;
            len_nxt   = '0;
            phase_nxt = PH_SKIP;
          end else if (len_r < nrte_pkg::LEN_W'(nrte_pkg::FIELD_CAPACITY)) begin
            if (len_r < nrte_pkg::LEN_W'(nrte_pkg::NIB_DEPTH)) begin
              nib_nxt[len_r[1:0]] = in_rx_byte[3:0];
            end
            len_nxt = len_r + 1'b1;
          end
        end
        PH_SKIP: begin
          // Consume the byte after the comma; publish only new digits.
          phase_nxt = PH_DOLLAR;
          if (changed) begin
            shown_nxt = pend_r;
            emit      = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_DOLLAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DOLLAR;
      len_r       <= '0;
      pend_r      <= nrte_pkg::PENDING_RESET;
      shown_r     <= nrte_pkg::SHOWN_RESET;
      out_valid_r <= 1'b0;
      zone_r      <= 4'd4;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
      shown_r <= shown_nxt;
      if (cfg_wr_en) begin
        zone_r <= cfg_zone_offset_hours;
      end
      // Load a new result or drop the one just taken.
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured nibbles and result payload need no reset.
  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
    if (emit) begin
      out_r <= pend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_tens    = out_r.hour_tens;
  assign out_hour_units   = out_r.hour_units;
  assign out_minute_tens  = out_r.minute_tens;
  assign out_minute_units = out_r.minute_units;

endmodule

// File: hdl/nrte_checker.sv
module nrte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hour_tens,
  input logic [3:0] out_hour_units,
  input logic [3:0] out_minute_tens,
  input logic [3:0] out_minute_units
);

  nrte_pkg::digits_t cur;
  nrte_pkg::digits_t last_r;

  assign cur = '{out_hour_tens, out_hour_units, out_minute_tens, out_minute_units};

  // Track the digits last taken by the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= nrte_pkg::SHOWN_RESET;
    end else if (out_valid && out_ready) begin
      last_r <= cur;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cur))
    else $error("result changed or dropped while stalled");

  a_new_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cur != last_r)
    else $error("result repeats the digits last shown");

  a_rose_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an input transaction");

  a_ready_only_blocked_by_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off with no stalled result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind nmea_rmc_time_extractor nrte_checker u_nrte_checker (.*);
